FILE: src/pstc_pkg.sv
// Shared types and constants for the pair-sum count table.
// Used by pair_sum_count_table and its port checker; no dependencies.
package pstc_pkg;

  // BUCKETS must be a power of two: the bucket is taken from the low bits of |key|.
  localparam int BUCKETS = 256;
  localparam int WAYS    = 4;

  localparam int ACT_W   = 2;
  localparam int VAL_W   = 32;
  localparam int KEY_W   = 34;
  localparam int CNT_W   = 32;
  localparam int TOT_W   = 64;
  localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam int IN_DATA_W  = 2 * VAL_W;
  localparam int OUT_DATA_W = CNT_W + TOT_W;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PROBE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] cnt;
  } slot_t;

  typedef slot_t [WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

endpackage

FILE: src/pstc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module pstc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/pair_sum_count_table.sv
// Top level of the pair-sum count table: bucket row RAM plus read-modify-write control.
// Depends on pstc_pkg and pstc_ram.
//
//  channel | dir | fields (low bit up)                               | handshake
//  s       | in  | tdata: first_value, second_value; tuser: action   | s_tvalid / s_tready
//  m       | out | tdata: match_count, running_total; tuser: status  | m_tvalid / m_tready
//
// An item passes two states: in S_IDLE the accept forms the key and bucket and reads the
// bucket row; in S_RMW the ways are compared, an insert with a hit or free way writes the
// row back, and the output word is loaded. The single RAM port pair allows one row read
// and at most one row write per item. A held output word stalls S_RMW; the next item is
// taken once it completes. Reset clears per-bucket valid flags; no memory sweep is needed.
module pair_sum_count_table (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [pstc_pkg::IN_DATA_W-1:0] s_tdata,   // first_value, second_value
  input  logic [pstc_pkg::ACT_W-1:0]     s_tuser,   // action
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [pstc_pkg::OUT_DATA_W-1:0] m_tdata,  // match_count, running_total
  output logic                           m_tuser    // status
);
  import pstc_pkg::*;

  typedef enum logic {S_IDLE, S_RMW} state_t;

  state_t             state;
  logic [ACT_W-1:0]   action;
  logic [KEY_W-1:0]   key;
  logic [BKT_W-1:0]   bucket;
  logic [TOT_W-1:0]   total;
  logic [BUCKETS-1:0] row_valid;

  logic               accept;
  logic               done;
  logic [VAL_W-1:0]   first_value;
  logic [VAL_W-1:0]   second_value;
  logic [VAL_W:0]     sum;
  logic [KEY_W-1:0]   key_next;
  logic [BKT_W-1:0]   mag_lo;
  logic [BKT_W-1:0]   bucket_next;

  logic [ROW_W-1:0]   rd_data;
  row_t               row_rd;
  row_t               row_next;
  logic               wr_en;
  logic               row_on;
  logic [WAYS-1:0]    way_vld;
  logic [WAYS-1:0]    way_hit;
  logic               hit_any;
  logic               free_any;
  logic [WAY_W-1:0]   hit_way;
  logic [WAY_W-1:0]   free_way;
  logic [CNT_W-1:0]   hit_cnt;
  logic [CNT_W-1:0]   inc_cnt;
  logic [CNT_W-1:0]   probe_cnt;
  logic [TOT_W:0]     tot_sum;
  logic [CNT_W-1:0]   count_next;
  logic [TOT_W-1:0]   total_next;
  logic               status_next;

  assign s_tready     = (state == S_IDLE);
  assign accept       = s_tvalid && s_tready;
  assign done         = (state == S_RMW) && (!m_tvalid || m_tready);
  assign first_value  = s_tdata[VAL_W-1:0];
  assign second_value = s_tdata[2*VAL_W-1:VAL_W];

  // |key| is |sum| for either action, so the bucket comes from the sum alone
  always_comb begin
    sum = {first_value[VAL_W-1], first_value} + {second_value[VAL_W-1], second_value};
    if (s_tuser == ACT_INSERT) begin
      key_next = {{2{~first_value[VAL_W-1]}}, ~first_value}
               + {{2{~second_value[VAL_W-1]}}, ~second_value} + KEY_W'(2);
    end else begin
      key_next = {sum[VAL_W], sum};
    end
    mag_lo      = sum[VAL_W] ? (~sum[BKT_W-1:0] + BKT_W'(1)) : sum[BKT_W-1:0];
    bucket_next = BKT_W'(mag_lo % BUCKETS);
  end

  pstc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (bucket),
    .wr_data (row_next),
    .rd_en   (accept),
    .rd_addr (bucket_next),
    .rd_data (rd_data)
  );

  // Compare ways; lowest matching way and lowest free way win
  always_comb begin
    row_rd   = row_t'(rd_data);
    row_on   = row_valid[bucket];
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      way_vld[w] = row_on && row_rd[w].vld;
      way_hit[w] = way_vld[w] && (row_rd[w].key == key);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (way_hit[w]) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!way_vld[w]) begin
        free_any = 1'b1;
        free_way = WAY_W'(w);
      end
    end
    hit_cnt   = row_rd[hit_way].cnt;
    inc_cnt   = (hit_cnt == CNT_MAX) ? hit_cnt : hit_cnt + CNT_W'(1);
    probe_cnt = hit_any ? hit_cnt : '0;
    tot_sum   = {1'b0, total} + (TOT_W+1)'(probe_cnt);
  end

  // Build write-back row and result word
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      row_next[w]     = row_rd[w];
      row_next[w].vld = way_vld[w];
    end
    wr_en       = 1'b0;
    count_next  = '0;
    total_next  = total;
    status_next = 1'b0;
    case (action)
      ACT_INSERT: begin
        if (hit_any) begin
          row_next[hit_way].cnt = inc_cnt;
          count_next            = inc_cnt;
          wr_en                 = done;
        end else if (free_any) begin
          row_next[free_way].vld = 1'b1;
          row_next[free_way].key = key;
          row_next[free_way].cnt = CNT_W'(1);
          count_next             = CNT_W'(1);
          wr_en                  = done;
        end else begin
          status_next = 1'b1;
        end
      end
      ACT_PROBE: begin
        count_next = probe_cnt;
        total_next = tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
      end
      ACT_CLEAR: begin
        total_next = '0;
      end
      default: begin
        count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      m_tvalid  <= 1'b0;
      total     <= '0;
      row_valid <= '0;
    end else begin
      // drop the word once taken, unless a new one replaces it
      if (m_tvalid && m_tready && !done) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            action <= s_tuser;
            key    <= key_next;
            bucket <= bucket_next;
            state  <= S_RMW;
          end
        end
        S_RMW: begin
          // hold until the output word is free
          if (done) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {total_next, count_next};
            m_tuser  <= status_next;
            total    <= total_next;
            if (action == ACT_CLEAR) begin
              row_valid <= '0;
            end else if (wr_en) begin
              row_valid[bucket] <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/pstc_check.sv
// Port-level checker for pair_sum_count_table, attached by bind.
// Depends on pstc_pkg.
module pstc_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [pstc_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tuser
);
  import pstc_pkg::*;

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  // one item at a time: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item accepted during read-modify-write");

  // a dropped insert reports no count
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[CNT_W-1:0] == '0)
    else $error("dropped insert with nonzero count");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind pair_sum_count_table pstc_check u_pstc_check (.*);

FILE: bench/pair_sum_count_table_chk.sv
`timescale 1ns / 100ps
// Checker for pair_sum_count_table: watches both stream channels, keeps its own copy of
// the bucket table and probe total, and compares every reply word. Depends on pstc_pkg.
module pair_sum_count_table_chk (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [pstc_pkg::IN_DATA_W-1:0]  s_tdata,   // first_value, second_value
  input  logic [pstc_pkg::ACT_W-1:0]      s_tuser,   // action
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [pstc_pkg::OUT_DATA_W-1:0] m_tdata,   // match_count, running_total
  input  logic                            m_tuser,   // status
  output int                              fail_count,
  output int                              replies_pending
);
  import pstc_pkg::*;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [TOT_W-1:0] total;
    logic             status;
  } table_reply_t;

  localparam int SLOTS = BUCKETS * WAYS;

  logic [KEY_W-1:0] tab_key [SLOTS];
  logic [CNT_W-1:0] tab_cnt [SLOTS];
  bit               tab_vld [SLOTS];
  logic [TOT_W-1:0] probe_total;
  table_reply_t     replies_due [$];

  // Update the table copy for one word and return the reply it must produce.
  function automatic table_reply_t apply_word(input logic [ACT_W-1:0] act,
                                              input logic [VAL_W-1:0] fv,
                                              input logic [VAL_W-1:0] sv);
    logic signed [KEY_W-1:0] pair_sum;
    logic signed [KEY_W-1:0] key;
    logic [KEY_W-1:0]        mag;
    logic [TOT_W:0]          wide_total;
    int                      base;
    int                      hit;
    int                      free_way;
    table_reply_t            r;
    r = '0;
    pair_sum = $signed({{2{fv[VAL_W-1]}}, fv}) + $signed({{2{sv[VAL_W-1]}}, sv});
    key = (act == ACT_INSERT) ? -pair_sum : pair_sum;
    mag = key[KEY_W-1] ? -key : key;
    base = int'(mag % BUCKETS) * WAYS;
    hit = -1;
    free_way = -1;
    for (int w = 0; w < WAYS; w++) begin
      if (tab_vld[base+w] && tab_key[base+w] == key && hit < 0) hit = base + w;
      if (!tab_vld[base+w] && free_way < 0) free_way = base + w;
    end
    case (act)
      ACT_INSERT: begin
        if (hit >= 0) begin
          if (tab_cnt[hit] != CNT_MAX) tab_cnt[hit] = tab_cnt[hit] + 1'b1;
          r.count = tab_cnt[hit];
        end else if (free_way >= 0) begin
          tab_vld[free_way] = 1'b1;
          tab_key[free_way] = key;
          tab_cnt[free_way] = CNT_W'(1);
          r.count = CNT_W'(1);
        end else begin
          r.status = 1'b1;
        end
      end
      ACT_PROBE: begin
        if (hit >= 0) r.count = tab_cnt[hit];
        wide_total = {1'b0, probe_total} + (TOT_W+1)'(r.count);
        probe_total = wide_total[TOT_W] ? '1 : wide_total[TOT_W-1:0];
      end
      ACT_CLEAR: begin
        foreach (tab_vld[i]) tab_vld[i] = 1'b0;
        probe_total = '0;
      end
      default: ;
    endcase
    r.total = probe_total;
    return r;
  endfunction

  always @(posedge clk) begin
    table_reply_t due;
    table_reply_t seen;
    if (rst) begin
      foreach (tab_vld[i]) tab_vld[i] = 1'b0;
      probe_total = '0;
      replies_due.delete();
      fail_count = 0;
    end else begin
      // check the outgoing word first: it always belongs to an earlier input word
      if (m_tvalid && m_tready) begin
        seen.count  = m_tdata[CNT_W-1:0];
        seen.total  = m_tdata[CNT_W +: TOT_W];
        seen.status = m_tuser;
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected reply count %0d total %0d status %0d",
                   $time, seen.count, seen.total, seen.status);
          fail_count++;
        end else begin
          due = replies_due.pop_front();
          if (seen.count !== due.count) begin
            $display("%0t: match_count expected %0d, got %0d", $time, due.count, seen.count);
            fail_count++;
          end
          if (seen.total !== due.total) begin
            $display("%0t: running_total expected %0d, got %0d",
                     $time, due.total, seen.total);
            fail_count++;
          end
          if (seen.status !== due.status) begin
            $display("%0t: status expected %0d, got %0d", $time, due.status, seen.status);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready)
        replies_due.push_back(apply_word(s_tuser, s_tdata[VAL_W-1:0], s_tdata[VAL_W +: VAL_W]));
    end
    replies_pending = replies_due.size();
  end

endmodule

FILE: bench/pair_sum_count_table_tb.sv
`timescale 1ns / 100ps
// Stimulus and verdict for pair_sum_count_table: directed table cases, then random
// insert/probe/clear/unused-action traffic with random gaps on both channels. Depends on pstc_pkg
// and pair_sum_count_table_chk.
module pair_sum_count_table_tb;
  import pstc_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam int RANDOM_WORDS   = 450;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES    = 16;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [ACT_W-1:0]      s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  int                    fail_count;
  int                    replies_pending;
  int                    quiet_cycles;
  bit                    send_steady;
  bit                    take_steady;

  pair_sum_count_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  pair_sum_count_table_chk chk (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .fail_count      (fail_count),
    .replies_pending (replies_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Idle cycles before the next word; now and then switch between gappy and steady runs.
  function automatic int draw_gap(ref bit steady);
    if ($urandom_range(0, 39) == 0) steady = !steady;
    return steady ? 0 : $urandom_range(0, 8);
  endfunction

  // Values from three pools: small (sums cancel often), spaced by 128 (buckets fill up),
  // and full range.
  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return VAL_W'($urandom_range(0, 24)) - 32'd12;
    if (r < 80)
      return VAL_W'($urandom_range(0, 16)) * 32'd128 - 32'd1024
             + VAL_W'($urandom_range(0, 4)) - 32'd2;
    return $urandom();
  endfunction

  // Present one word at a falling edge and hold it until accepted.
  task automatic push_word(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] fv,
                           input logic [VAL_W-1:0] sv);
    int gap;
    gap = draw_gap(send_steady);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {sv, fv};
    s_tuser  <= act;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      int gap;
      gap = draw_gap(take_steady);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("pair_sum_count_table_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int unsigned r;
    logic [ACT_W-1:0] act;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = ACT_INSERT;
    send_steady = 1'b0;
    take_steady = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // extremes of the addends
    push_word(ACT_PROBE, 0, 0);
    push_word(ACT_INSERT, VAL_MIN, VAL_MIN);
    push_word(ACT_INSERT, VAL_MAX, VAL_MAX);
    push_word(ACT_PROBE, VAL_MIN, VAL_MIN + 32'd2);
    push_word(ACT_PROBE, VAL_MAX, VAL_MAX);
    // keys of both signs sharing bucket 5, then one more to overflow it
    push_word(ACT_INSERT, 5, 0);
    push_word(ACT_INSERT, -5, 0);
    push_word(ACT_INSERT, -261, 0);
    push_word(ACT_INSERT, 261, 0);
    push_word(ACT_INSERT, -517, 0);
    push_word(ACT_INSERT, 2, 3);
    push_word(ACT_PROBE, -5, 0);
    push_word(ACT_PROBE, 0, 5);
    push_word(ACT_PROBE, 517, 0);
    push_word(ACT_UNUSED, 1, 2);
    push_word(ACT_CLEAR, VAL_MAX, VAL_MIN);
    push_word(ACT_PROBE, -2, -3);
    push_word(ACT_INSERT, VAL_MAX, VAL_MIN);
    push_word(ACT_INSERT, 0, -1);
    push_word(ACT_PROBE, 1, 0);
    push_word(ACT_INSERT, 0, 0);
    push_word(ACT_PROBE, 0, 0);
    push_word(ACT_CLEAR, 0, 0);

    repeat (RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 2) act = ACT_UNUSED;
      else if (r < 4) act = ACT_CLEAR;
      else if (r < 52) act = ACT_INSERT;
      else act = ACT_PROBE;
      push_word(act, pick_value(), pick_value());
    end
    s_tvalid <= 1'b0;

    while (replies_pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("pair_sum_count_table_tb OK");
    end else begin
      $display("pair_sum_count_table_tb NOT OK");
    end
    $finish;
  end

endmodule
